### src/timer_bank_oneshot_periodic_macros.svh
// Assertion macros for the timer bank.
`ifndef TIMER_BANK_ONESHOT_PERIODIC_MACROS_SVH
`define TIMER_BANK_ONESHOT_PERIODIC_MACROS_SVH

// same-cycle implication, reset masked
`define TBOP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define TBOP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/tbop_pkg.sv
// Types and constants shared by the timer bank modules.
package tbop_pkg;

	localparam int TICK_W  = 32;
	localparam int CH_W    = 4;
	localparam int MODE_W  = 2;
	localparam int FIRED_W = 16;

	localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

	// check token walking down the cell row
	typedef struct packed {
		logic              vld;
		logic [TICK_W-1:0] now;
	} link_t;

	// start/stop command broadcast to all cells
	typedef struct packed {
		logic              start;
		logic              stop;
		logic              periodic;
		logic [TICK_W-1:0] period;
		logic [TICK_W-1:0] now;
	} cmd_t;

endpackage

### src/tbop_req_if.sv
// Request channel: one operation word per handshake.
interface tbop_req_if;
	import tbop_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [CH_W-1:0]   channel;
	logic              periodic;
	logic [TICK_W-1:0] period_ticks;
	logic [TICK_W-1:0] now_ticks;

	modport source (output valid, mode, channel, periodic, period_ticks, now_ticks,
		input ready);
	modport sink (input valid, mode, channel, periodic, period_ticks, now_ticks,
		output ready);
endinterface

### src/tbop_rsp_if.sv
// Response channel: one fired-mask word per handshake.
interface tbop_rsp_if;
	import tbop_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIRED_W-1:0] fired_mask;

	modport source (output valid, fired_mask, input ready);
	modport sink (input valid, fired_mask, output ready);
endinterface

### src/tbop_cell.sv
// One timer channel: holds its state, tests the passing check token.
module tbop_cell import tbop_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  sel,
	input  cmd_t  cmd,
	input  link_t link_in,
	output link_t link_out,
	output logic  fire
);

	logic              run_q;
	logic              per_q;
	logic [TICK_W-1:0] period_q;
	logic [TICK_W-1:0] start_q;
	logic [TICK_W-1:0] elapsed;
	logic              link_vld_q;
	logic [TICK_W-1:0] link_now_q;

	assign elapsed  = link_in.now - start_q;
	assign fire     = link_in.vld && run_q && (elapsed > period_q);
	assign link_out = {link_vld_q, link_now_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			link_vld_q <= 1'b0;
		end else begin
			link_vld_q <= link_in.vld;
			if (sel && cmd.start) begin
				run_q <= 1'b1;
			end else if (sel && cmd.stop) begin
				run_q <= 1'b0;
			end else if (fire && !per_q) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		link_now_q <= link_in.now;
		if (sel && cmd.start) begin
			per_q    <= cmd.periodic;
			period_q <= cmd.period;
			start_q  <= cmd.now;
		end else if (sel && cmd.stop) begin
			start_q <= '0;
		end else if (fire) begin
			// periodic: rearm one period on; one-shot: clear
			start_q <= per_q ? (start_q + period_q) : '0;
		end
	end

endmodule

### src/timer_bank_oneshot_periodic.sv
// Check: token reg, each cell's link reg, then result reg once rsp is free.
// Start, stop, unused: zero word the cycle after; one item a cycle while rsp is ready.
// The token walks one channel per cycle; no new request is taken until its word loads.
// The result register frees the input side in the cycle its word is taken.
// arst_n clears all run flags and the control; period/start need no reset.
// Top level of the timer bank.
module timer_bank_oneshot_periodic import tbop_pkg::*; #(
	parameter int NUM_TIMERS = 16
) (
	input  logic clk,
	input  logic arst_n,
	tbop_req_if.sink   req,
	tbop_rsp_if.source rsp
);

	`include "timer_bank_oneshot_periodic_macros.svh"

	state_t state_q, state_d;

	// token register feeding cell 0, and the row of links between cells
	logic                  tok_vld_q;
	logic [TICK_W-1:0]     tok_now_q;
	link_t                 link [NUM_TIMERS+1];
	logic [NUM_TIMERS:0]   tok_vec;
	logic [NUM_TIMERS-1:0] fire;
	logic [NUM_TIMERS-1:0] sel;
	logic [NUM_TIMERS-1:0] mask_q;
	logic [NUM_TIMERS+FIRED_W-1:0] mask_ext;

	// result register
	logic               rsp_vld_q;
	logic [FIRED_W-1:0] rsp_mask_q;

	cmd_t cmd;
	logic rsp_free;
	logic accept;
	logic is_check;
	logic launch;
	logic load_zero;
	logic load_mask;
	logic scan_done;

	assign rsp_free  = !rsp_vld_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_check  = (req.mode == MODE_CHECK);
	assign scan_done = link[NUM_TIMERS].vld;

	assign cmd.start    = accept && (req.mode == MODE_START);
	assign cmd.stop     = accept && (req.mode == MODE_STOP);
	assign cmd.periodic = req.periodic;
	assign cmd.period   = req.period_ticks;
	assign cmd.now      = req.now_ticks;

	assign link[0] = {tok_vld_q, tok_now_q};

	// bits above the bank read as zero; channels past bit 15 are dropped
	assign mask_ext = {{FIRED_W{1'b0}}, mask_q};

	genvar gi;
	generate
		for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
			// a channel number beyond the bank matches no cell
			assign sel[gi] = (32'(req.channel) == 32'(gi));

			tbop_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.sel      (sel[gi]),
				.cmd      (cmd),
				.link_in  (link[gi]),
				.link_out (link[gi+1]),
				.fire     (fire[gi])
			);
		end
		for (gi = 0; gi <= NUM_TIMERS; gi++) begin : g_tok
			assign tok_vec[gi] = link[gi].vld;
		end
	endgenerate

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_check) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		launch    = 1'b0;
		load_zero = 1'b0;
		load_mask = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = rsp_free;
				launch    = accept && is_check;
				load_zero = accept && !is_check;
			end
			ST_SCAN: begin
			end
			ST_HOLD: begin
				load_mask = rsp_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tok_vld_q <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			tok_vld_q <= launch;
			if (load_zero || load_mask) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_now_q <= req.now_ticks;
		// fired bits gather as the token passes each cell
		if (launch) begin
			mask_q <= '0;
		end else begin
			mask_q <= mask_q | fire;
		end
		if (load_zero) begin
			rsp_mask_q <= '0;
		end else if (load_mask) begin
			rsp_mask_q <= mask_ext[FIRED_W-1:0];
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.fired_mask = rsp_mask_q;

	`TBOP_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vec), "more than one check token in the row")
	`TBOP_ASSERT_NOW(a_token_scan, state_q != ST_SCAN, tok_vec == '0, "check token outside a scan")
	`TBOP_ASSERT_NEXT(a_cmd_zero, accept && !is_check, rsp.valid && (rsp.fired_mask == '0), "start or stop gave no zero word")

endmodule

### verif/tbop_tb_pkg.sv
// Operation word type and fired-mask scoreboard for the timer bank testbench.
package tbop_tb_pkg;
	import tbop_pkg::*;

	localparam int NUM_CH = 16;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CH_W-1:0]   channel;
		logic              periodic;
		logic [TICK_W-1:0] period_ticks;
		logic [TICK_W-1:0] now_ticks;
	} timer_op_t;

	class fired_mask_tracker;
		bit                 running[NUM_CH];
		bit                 repeats[NUM_CH];
		logic [TICK_W-1:0]  period[NUM_CH];
		logic [TICK_W-1:0]  start[NUM_CH];
		logic [FIRED_W-1:0] masks_due[$];
		int                 errors;
		int                 words_seen;
		int                 fires_seen;
		int                 ops_seen[4];

		function new();
			for (int i = 0; i < NUM_CH; i++) begin
				running[i] = 1'b0;
				repeats[i] = 1'b0;
				period[i]  = '0;
				start[i]   = '0;
			end
			errors     = 0;
			words_seen = 0;
			fires_seen = 0;
			foreach (ops_seen[k]) ops_seen[k] = 0;
		endfunction

		// apply one accepted operation word, queue the mask it must produce
		function void take_op(timer_op_t op);
			logic [FIRED_W-1:0] mask;
			logic [TICK_W-1:0]  elapsed;
			mask = '0;
			ops_seen[op.mode]++;
			case (op.mode)
				MODE_CHECK: begin
					for (int i = 0; i < NUM_CH; i++) begin
						if (!running[i])
							continue;
						elapsed = op.now_ticks - start[i];
						if (elapsed > period[i]) begin
							mask[i] = 1'b1;
							if (repeats[i]) begin
								start[i] = start[i] + period[i];
							end else begin
								running[i] = 1'b0;
								start[i]   = '0;
							end
						end
					end
				end
				MODE_START: begin
					repeats[op.channel] = op.periodic;
					period[op.channel]  = op.period_ticks;
					running[op.channel] = 1'b1;
					start[op.channel]   = op.now_ticks;
				end
				MODE_STOP: begin
					// mode and period stay
					running[op.channel] = 1'b0;
					start[op.channel]   = '0;
				end
				default: ;
			endcase
			masks_due.push_back(mask);
		endfunction

		task report(string msg);
			if (errors < 50)
				$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task match_mask(logic [FIRED_W-1:0] got);
			logic [FIRED_W-1:0] want;
			words_seen++;
			if (masks_due.size() == 0) begin
				report($sformatf("fired_mask %h arrived with no word outstanding", got));
				return;
			end
			want = masks_due.pop_front();
			fires_seen += $countones(want);
			if (got !== want)
				report($sformatf("fired_mask %h, predicted %h", got, want));
		endtask

		task drain_check();
			if (masks_due.size() != 0)
				report($sformatf("%0d result words never arrived", masks_due.size()));
		endtask
	endclass

endpackage

### verif/tb_timer_bank_oneshot_periodic.sv
// Testbench for the timer bank: directed and random operation words, scoreboarded.
module tb_timer_bank_oneshot_periodic;
	timeunit 1ns;
	timeprecision 1ps;

	import tbop_pkg::*;
	import tbop_tb_pkg::*;

	// random op count after the directed block
	localparam int RANDOM_OPS = 1450;
	// calm window (by random op index) where neither side idles
	localparam int CALM_FIRST = 500;
	localparam int CALM_LAST  = 800;
	// A check holds the request side through its scan; add a long ready stall and a sender
	// gap and the worst quiet stretch still stays well under this limit.
	localparam int STALL_LIMIT = 2000;
	// settle time after the last word, about two check passes
	localparam int TAIL_CYCLES = 2 * (NUM_CH + 2);

	logic clk = 1'b0;
	logic arst_n;
	bit   steady = 1'b0;
	int   quiet_cycles = 0;

	fired_mask_tracker board;

	tbop_req_if req();
	tbop_rsp_if rsp();

	timer_bank_oneshot_periodic #(
		.NUM_TIMERS(NUM_CH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side back-pressure: ready drops about a quarter of the time,
	// except in the calm window.
	always @(negedge clk) begin
		rsp.ready <= steady || ($urandom_range(99) >= 26);
	end

	// Monitor. Sampled at the rising edge, before the block's flops update.
	// The result word is checked ahead of the request noted at the same edge,
	// since a word can never come back in the cycle it was taken.
	always @(posedge clk) begin : watch
		timer_op_t op;
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				board.match_mask(rsp.fired_mask);
			if (req.valid && req.ready) begin
				op.mode         = req.mode;
				op.channel      = req.channel;
				op.periodic     = req.periodic;
				op.period_ticks = req.period_ticks;
				op.now_ticks    = req.now_ticks;
				board.take_op(op);
			end
		end
	end

	// Watchdog: counts edges where neither channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
			$display("tb_timer_bank_oneshot_periodic: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one operation word. Entered just after a falling edge and
	// returns just after the falling edge that follows acceptance, so valid
	// gets at most one update per edge and stays high between words outside a random sender gap.
	task automatic push_op(logic [MODE_W-1:0] mode, logic [CH_W-1:0] channel,
			logic periodic, logic [TICK_W-1:0] period_ticks,
			logic [TICK_W-1:0] now_ticks);
		while (!steady && $urandom_range(99) < 26) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid        <= 1'b1;
		req.mode         <= mode;
		req.channel      <= channel;
		req.periodic     <= periodic;
		req.period_ticks <= period_ticks;
		req.now_ticks    <= now_ticks;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
	endtask

	initial begin
		logic [TICK_W-1:0] tick;
		logic [TICK_W-1:0] span;
		logic [MODE_W-1:0] kind;
		int                pick;

		board            = new();
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.mode         = MODE_CHECK;
		req.channel      = '0;
		req.periodic     = 1'b0;
		req.period_ticks = '0;
		req.now_ticks    = '0;
		rsp.ready        = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed ---
		// empty bank, then the unused mode with every field at its top
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'd0);
		push_op(MODE_UNUSED, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// one-shot, zero period: no fire at zero elapsed, fires at one, then gone
		push_op(MODE_START, 4'd0, 1'b0, 32'd0, 32'd100);
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'd100);
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'd101);
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'd102);
		// periodic, zero period: fires on every advance, start never moves
		push_op(MODE_START, 4'd15, 1'b1, 32'd0, 32'd5);
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'd6);
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'd7);
		// periodic across the tick wrap: exactly the period does not fire
		push_op(MODE_START, 4'd1, 1'b1, 32'd10, 32'hFFFF_FFF8);
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'd2);
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'd3);
		// largest periods: all-ones can never fire, one below fires at the top
		push_op(MODE_START, 4'd2, 1'b0, 32'hFFFF_FFFF, 32'd0);
		push_op(MODE_START, 4'd3, 1'b1, 32'hFFFF_FFFE, 32'd0);
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'hFFFF_FFFF);
		// stop a running channel, a never-started one, and the unfireable one
		push_op(MODE_STOP, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(MODE_STOP, 4'd7, 1'b0, 32'd0, 32'd0);
		push_op(MODE_STOP, 4'd2, 1'b0, 32'd0, 32'd0);
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'hFFFF_FFFF);
		// restart after a stop with a new mode and period
		push_op(MODE_START, 4'd15, 1'b0, 32'd3, 32'h10);
		push_op(MODE_CHECK, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'h13);
		push_op(MODE_CHECK, 4'd0, 1'b0, 32'd0, 32'h14);

		// --- random ---
		// A free-running tick creeps forward in small steps so elapsed counts
		// sit near the periods; now and then it jumps anywhere or near the wrap.
		tick = $urandom;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			steady = (n >= CALM_FIRST && n < CALM_LAST);

			pick = $urandom_range(99);
			if (pick < 6)
				tick = $urandom;
			else if (pick < 9)
				tick = 32'hFFFF_FFFF - $urandom_range(60);
			else
				tick = tick + $urandom_range(12);

			pick = $urandom_range(99);
			if (pick < 42)
				kind = MODE_CHECK;
			else if (pick < 78)
				kind = MODE_START;
			else if (pick < 95)
				kind = MODE_STOP;
			else
				kind = MODE_UNUSED;

			pick = $urandom_range(99);
			if (pick < 10)
				span = '0;
			else if (pick < 75)
				span = $urandom_range(40);
			else if (pick < 94)
				span = $urandom;
			else
				span = 32'hFFFF_FFFF - $urandom_range(3);

			push_op(kind, CH_W'($urandom_range(NUM_CH - 1)), 1'($urandom_range(1)),
				span, tick);
		end
		steady = 1'b0;
		req.valid <= 1'b0;

		// drain, then give the block time to show any stray word
		while (board.masks_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		board.drain_check();

		$display("run: %0d result words compared, %0d channel fires among them, %0d mismatches",
			board.words_seen, board.fires_seen, board.errors);
		$display("run: ops taken - check %0d, start %0d, stop %0d, unused %0d",
			board.ops_seen[MODE_CHECK], board.ops_seen[MODE_START],
			board.ops_seen[MODE_STOP], board.ops_seen[MODE_UNUSED]);
		if (board.errors == 0) begin
			$display("tb_timer_bank_oneshot_periodic: done, clean");
		end else begin
			$display("tb_timer_bank_oneshot_periodic: done, errors");
		end
		$finish;
	end

endmodule
